// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GCIE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define GCIE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// File: src/gcie_pkg.sv
`timescale 1ns / 1ps

package gcie_pkg;

	// defaults for the top-level parameters
	localparam int DEF_KEY_COLUMNS = 4;
	localparam int DEF_MAX_LEVELS  = 256;
	localparam int DEF_VALUE_WIDTH = 32;

	// key fields carried by one classify transaction
	localparam int KEY_FIELDS = 4;

	// field widths
	localparam int KEY_W   = 32;
	localparam int COL_W   = 2;
	localparam int POS_W   = 8;
	localparam int ROW_W   = 32;
	localparam int IDX_W   = 32;
	localparam int KEYS_W  = 3;
	localparam int CNT_W   = 9;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int RIDX_W  = 3;

	// opcodes
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// register indexes
	localparam logic [RIDX_W-1:0] REG_KEYS    = 3'd0;
	localparam logic [RIDX_W-1:0] REG_COUNT_0 = 3'd1;
	localparam logic [RIDX_W-1:0] REG_COUNT_1 = 3'd2;
	localparam logic [RIDX_W-1:0] REG_COUNT_2 = 3'd3;
	localparam logic [RIDX_W-1:0] REG_COUNT_3 = 3'd4;

	typedef struct packed {
		logic                    opcode;
		logic [COL_W-1:0]        load_column;
		logic [POS_W-1:0]        load_position;
		logic signed [KEY_W-1:0] load_value;
		logic signed [KEY_W-1:0] key_value_0;
		logic signed [KEY_W-1:0] key_value_1;
		logic signed [KEY_W-1:0] key_value_2;
		logic signed [KEY_W-1:0] key_value_3;
		logic [ROW_W-1:0]        row_number;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_index;
		logic [ROW_W-1:0] row_tag;
		logic             out_of_range;
	} out_item_t;

endpackage

// File: src/group_cell_index_encoder.sv
`timescale 1ns / 1ps

// group-by cell encoder
// input channel (in_valid / in_stall / in_data) carries load and classify
// transactions. a load writes one level table entry in the accepting cycle and
// gives no result; the next transaction may follow in the following cycle.
// a classify runs a lower-bound binary search per key column, all columns in
// parallel lanes with one table probe per cycle from each lane's own ram,
// then folds the positions into the cell index one key per cycle.
// a classify waits until the search of every lane in use is over, which the
// largest level count in use sets, then starts the merge, folds the keys and
// loads the output register. in_stall stays high from the accepted classify
// until its result is registered; no other transaction is taken meanwhile.
// the output register holds a result while out_stall is high; a new input
// transaction is still taken then, and a further classify waits at the end
// of its merge until the register frees.
// reset clears the control state and sets keys_in_use and the level counts
// to 1; level tables are undefined until loaded. configuration goes through
// the apb port with pready tied high, registers at byte address 4*index.
module group_cell_index_encoder #(
	parameter int KEY_COLUMNS = gcie_pkg::DEF_KEY_COLUMNS,
	parameter int MAX_LEVELS  = gcie_pkg::DEF_MAX_LEVELS,
	parameter int VALUE_WIDTH = gcie_pkg::DEF_VALUE_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  gcie_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output gcie_pkg::out_item_t         out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gcie_pkg::ADDR_W-1:0] paddr,
	input  logic [gcie_pkg::DATA_W-1:0] pwdata,
	output logic [gcie_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import gcie_pkg::*;

	localparam int LANES = (KEY_COLUMNS < KEY_FIELDS) ? KEY_COLUMNS : KEY_FIELDS;
	localparam int AW    = $clog2(MAX_LEVELS);
	localparam int CW    = $clog2(MAX_LEVELS + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_MERGE  = 3'b100
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [KEYS_W-1:0] keys_q;
	logic [CNT_W-1:0]  count_q [KEY_FIELDS];
	logic [KEYS_W-1:0] keys_eff;
	logic [CW-1:0]     cnt_eff [LANES];
	logic [CW-1:0]     lane_pos [LANES];
	logic [LANES-1:0]  lane_busy;
	logic [KEY_W-1:0]  key_in [KEY_FIELDS];
	logic [ROW_W-1:0]  row_q;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic              cfg_wr;
	logic              in_acc;
	logic              load_acc;
	logic              classify_acc;
	logic              pos_ok;
	logic              merge_start;
	logic              merge_done;
	logic [IDX_W-1:0]  merge_index;
	logic              out_free;
	logic              out_load;
	logic              oor;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= KEYS_W'(1);
			for (int i = 0; i < KEY_FIELDS; i++) begin
				count_q[i] <= CNT_W'(1);
			end
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_KEYS:    keys_q     <= pwdata[KEYS_W-1:0];
				REG_COUNT_0: count_q[0] <= pwdata[CNT_W-1:0];
				REG_COUNT_1: count_q[1] <= pwdata[CNT_W-1:0];
				REG_COUNT_2: count_q[2] <= pwdata[CNT_W-1:0];
				REG_COUNT_3: count_q[3] <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[4:2])
			REG_KEYS:    prdata = DATA_W'(keys_q);
			REG_COUNT_0: prdata = DATA_W'(count_q[0]);
			REG_COUNT_1: prdata = DATA_W'(count_q[1]);
			REG_COUNT_2: prdata = DATA_W'(count_q[2]);
			REG_COUNT_3: prdata = DATA_W'(count_q[3]);
			default:     prdata = '0;
		endcase
	end

	// effective key count, clamped to the lanes present
	always_comb begin
		if (keys_q == '0) begin
			keys_eff = KEYS_W'(1);
		end else if (32'(keys_q) > 32'(LANES)) begin
			keys_eff = KEYS_W'(LANES);
		end else begin
			keys_eff = keys_q;
		end
	end

	// input acceptance
	assign in_stall     = (state_q != S_IDLE);
	assign in_acc       = in_valid & ~in_stall;
	assign load_acc     = in_acc & (in_data.opcode == OP_LOAD);
	assign classify_acc = in_acc & (in_data.opcode == OP_CLASSIFY);
	assign pos_ok       = 32'(in_data.load_position) < 32'(MAX_LEVELS);

	assign key_in[0] = in_data.key_value_0;
	assign key_in[1] = in_data.key_value_1;
	assign key_in[2] = in_data.key_value_2;
	assign key_in[3] = in_data.key_value_3;

	// search lanes, one per key column; only the columns in use are searched
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_comb begin
			if (count_q[l] == '0) begin
				cnt_eff[l] = CW'(1);
			end else if (32'(count_q[l]) > 32'(MAX_LEVELS)) begin
				cnt_eff[l] = CW'(MAX_LEVELS);
			end else begin
				cnt_eff[l] = CW'(count_q[l]);
			end
		end

		gcie_lane #(
			.MAX_LEVELS (MAX_LEVELS),
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (classify_acc & (32'(l) < 32'(keys_eff))),
			.key     (key_in[l]),
			.count   (cnt_eff[l]),
			.wr_en   (load_acc & pos_ok & (in_data.load_column == COL_W'(l))),
			.wr_addr (AW'(in_data.load_position)),
			.wr_data (in_data.load_value[VALUE_WIDTH-1:0]),
			.busy    (lane_busy[l]),
			.position(lane_pos[l])
		);
	end

	// merging stage
	assign merge_start = (state_q == S_SEARCH) && (lane_busy == '0);

	gcie_merge #(
		.LANES(LANES),
		.CW   (CW)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (merge_start),
		.keys      (keys_eff),
		.pos       (lane_pos),
		.cnt       (cnt_eff),
		.done      (merge_done),
		.cell_index(merge_index)
	);

	// out of range when a key in use sits past its last level
	always_comb begin
		oor = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			if ((32'(l) < 32'(keys_eff)) && (lane_pos[l] == cnt_eff[l])) begin
				oor = 1'b1;
			end
		end
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign out_load = (state_q == S_MERGE) && merge_done && out_free;

	// control sequence
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (classify_acc) state_d = S_SEARCH;
			S_SEARCH: if (merge_start) state_d = S_MERGE;
			S_MERGE:  if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row number travels alongside the search
	always_ff @(posedge clk) begin
		if (classify_acc) begin
			row_q <= in_data.row_number;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.cell_index   <= merge_index;
			out_data_q.row_tag      <= row_q;
			out_data_q.out_of_range <= oor;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: src/gcie_ram.sv
`timescale 1ns / 1ps

module gcie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// File: src/gcie_lane.sv
`timescale 1ns / 1ps

module gcie_lane #(
	parameter int MAX_LEVELS  = gcie_pkg::DEF_MAX_LEVELS,
	parameter int VALUE_WIDTH = gcie_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [gcie_pkg::KEY_W-1:0]        key,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]   count,
	input  logic                              wr_en,
	input  logic [$clog2(MAX_LEVELS)-1:0]     wr_addr,
	input  logic [VALUE_WIDTH-1:0]            wr_data,
	output logic                              busy,
	output logic [$clog2(MAX_LEVELS+1)-1:0]   position
);
	import gcie_pkg::*;

	localparam int AW = $clog2(MAX_LEVELS);
	localparam int CW = $clog2(MAX_LEVELS + 1);

	logic                          busy_q;
	logic [CW-1:0]                 first_q;
	logic [CW-1:0]                 len_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0]        rd_data;
	logic [AW-1:0]                 rd_addr;
	logic [CW-1:0]                 half;
	logic [CW-1:0]                 nfirst;
	logic [CW-1:0]                 nlen;
	logic                          lt;

	gcie_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(MAX_LEVELS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// one lower-bound probe per cycle on the entry read last cycle
	always_comb begin
		half   = len_q >> 1;
		lt     = $signed(rd_data) < key_q;
		nfirst = lt ? CW'(first_q + half + CW'(1)) : first_q;
		nlen   = lt ? CW'(len_q - half - CW'(1)) : half;
		if (start) begin
			rd_addr = AW'(count >> 1);
		end else begin
			rd_addr = AW'(nfirst + (nlen >> 1));
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= '0;
			len_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			first_q <= '0;
			len_q   <= count;
		end else if (busy_q) begin
			busy_q  <= (nlen != '0);
			first_q <= nfirst;
			len_q   <= nlen;
		end
	end

	// key held for the whole search
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key[VALUE_WIDTH-1:0];
		end
	end

	assign busy     = busy_q;
	assign position = first_q;

endmodule

// File: src/gcie_merge.sv
`timescale 1ns / 1ps

module gcie_merge #(
	parameter int LANES = gcie_pkg::KEY_FIELDS,
	parameter int CW    = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gcie_pkg::KEYS_W-1:0] keys,
	input  logic [CW-1:0]               pos [LANES],
	input  logic [CW-1:0]               cnt [LANES],
	output logic                        done,
	output logic [gcie_pkg::IDX_W-1:0]  cell_index
);
	import gcie_pkg::*;

	localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;

	logic             busy_q;
	logic             done_q;
	logic [LIW-1:0]   nxt_q;
	logic [IDX_W-1:0] acc_q;
	logic [LIW-1:0]   top_k;

	assign top_k = LIW'(keys - KEYS_W'(1));

	// horner fold from the most significant key down, one key a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			nxt_q  <= '0;
			acc_q  <= '0;
		end else if (start) begin
			acc_q <= IDX_W'(pos[top_k]);
			if (keys > KEYS_W'(1)) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				nxt_q  <= LIW'(keys - KEYS_W'(2));
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (busy_q) begin
			acc_q <= IDX_W'(acc_q * IDX_W'(cnt[nxt_q])) + IDX_W'(pos[nxt_q]);
			if (nxt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				nxt_q <= nxt_q - LIW'(1);
			end
		end
	end

	assign done       = done_q;
	assign cell_index = acc_q;

endmodule

// File: src/gcie_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcie_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input gcie_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input gcie_pkg::out_item_t out_data
);
	import gcie_pkg::*;

	// a stalled result holds
	`GCIE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// a classify transaction blocks the input while it is searched
	`GCIE_ASSERT_NEXT(a_classify_stall, clk, arst_n, in_valid && !in_stall && (in_data.opcode == OP_CLASSIFY), in_stall, "input taken during a search")

	// a load transaction leaves the input open
	`GCIE_ASSERT_NEXT(a_load_open, clk, arst_n, in_valid && !in_stall && (in_data.opcode == OP_LOAD), !in_stall, "load stalled the input")

	// a new result only appears at the end of a classify
	`GCIE_ASSERT(a_result_source, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "result without a classify")

endmodule

bind group_cell_index_encoder gcie_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
